FILE: rtl/core/blzd_pkg.sv
// ----------------------------------------------------------------------------
// blzd_pkg
// Shared constants and controller/datapath interface types for the backward
// LZ decompressor.
// ----------------------------------------------------------------------------
package blzd_pkg;

  localparam int WINDOW_DEPTH_DEF = 8192;

  localparam int BYTE_W  = 8;
  localparam int DIST_W  = 13;  // holds the largest distance, 0xFFF + 3
  localparam int LEN_W   = 5;   // holds the largest length, 15 + 3
  localparam int LEFT_W  = 4;   // holds the flag count, 8

  localparam logic [LEFT_W-1:0] FLAG_COUNT = LEFT_W'(8);
  localparam logic [DIST_W-1:0] DIST_BIAS  = DIST_W'(3);
  localparam logic [LEN_W-1:0]  LEN_BIAS   = LEN_W'(3);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_wr;    // write zero at the write position during the clearing pass
    logic accept;      // take the input request
    logic copy_rd;     // read the window at the copy source
    logic copy_emit;   // emit the byte just read and write it back
  } blzd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic wp_last;     // write position is at the top of the window
    logic copy_next;   // the next accepted byte completes a copy pair
    logic cnt_last;    // one copy byte left
    logic out_free;    // output register can take a byte this cycle
  } blzd_sts_t;

endpackage

FILE: rtl/core/blzd_ctrl.sv
// ----------------------------------------------------------------------------
// blzd_ctrl
// Controller: clearing pass after reset, request acceptance and the
// read/write sequence of a copy token.
// ----------------------------------------------------------------------------
module blzd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  blzd_pkg::blzd_sts_t sts,
  output blzd_pkg::blzd_cmd_t cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_WRITE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.wp_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = !sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.accept = 1'b1;
          if (sts.copy_next) begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.copy_rd = 1'b1;
        state_nxt   = S_WRITE;
      end
      S_WRITE: begin
        // The read data stays registered until the output can take it.
        if (sts.out_free) begin
          cmd.copy_emit = 1'b1;
          state_nxt     = sts.cnt_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/blzd_datapath.sv
// ----------------------------------------------------------------------------
// blzd_datapath
// Token parser registers, history window memory, copy counters and the
// output register.
// ----------------------------------------------------------------------------
module blzd_datapath #(
  parameter int WINDOW_DEPTH = blzd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  blzd_pkg::blzd_cmd_t         cmd,
  output blzd_pkg::blzd_sts_t         sts,
  input  logic [blzd_pkg::BYTE_W-1:0] in_packed_byte,
  input  logic                        in_final_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [blzd_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_run_last,
  output logic                        out_stream_done
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(WINDOW_DEPTH);
  localparam logic [AW-1:0] TOP_POS = AW'(WINDOW_DEPTH - 1);

  logic [blzd_pkg::BYTE_W-1:0] window_mem [WINDOW_DEPTH];

  logic [AW-1:0]                 wp_r;
  logic [AW-1:0]                 wp_nxt;
  logic [blzd_pkg::BYTE_W-1:0]   flag_r;
  logic [blzd_pkg::BYTE_W-1:0]   flag_nxt;
  logic [blzd_pkg::LEFT_W-1:0]   left_r;
  logic [blzd_pkg::LEFT_W-1:0]   left_nxt;
  logic [blzd_pkg::BYTE_W-1:0]   pair_high_r;
  logic [blzd_pkg::BYTE_W-1:0]   pair_high_nxt;
  logic                          await_low_r;
  logic                          await_low_nxt;
  logic [blzd_pkg::DIST_W-1:0]   dist_r;
  logic [blzd_pkg::LEN_W-1:0]    cnt_r;
  logic [blzd_pkg::LEN_W-1:0]    cnt_nxt;
  logic                          fin_r;
  logic [blzd_pkg::BYTE_W-1:0]   rd_data_r;
  logic                          out_valid_r;
  logic [blzd_pkg::BYTE_W-1:0]   out_byte_r;
  logic                          run_last_r;
  logic                          stream_done_r;

  logic                          expect_flag;
  logic                          take_flag;
  logic                          take_low;
  logic                          take_lit;
  logic                          take_high;
  logic                          mem_we;
  logic [blzd_pkg::BYTE_W-1:0]   mem_wdata;
  logic [AW:0]                   wp_ext;
  logic [AW:0]                   dist_ext;
  logic [AW-1:0]                 src_addr;
  logic [blzd_pkg::DIST_W-1:0]   dist_new;

  assign expect_flag = (left_r == '0);
  assign take_flag   = cmd.accept && expect_flag;
  assign take_low    = cmd.accept && !expect_flag && await_low_r;
  assign take_lit    = cmd.accept && !expect_flag && !await_low_r && !flag_r[7];
  assign take_high   = cmd.accept && !expect_flag && !await_low_r && flag_r[7];

  assign sts.wp_last   = (wp_r == TOP_POS);
  assign sts.copy_next = await_low_r;
  assign sts.cnt_last  = (cnt_r == blzd_pkg::LEN_W'(1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign dist_new = {1'b0, pair_high_r[3:0], in_packed_byte} + blzd_pkg::DIST_BIAS;

  // Copy source, wrapped into the window.
  assign wp_ext   = {1'b0, wp_r};
  assign dist_ext = (AW+1)'(dist_r);
  always_comb begin
    if (wp_ext >= dist_ext) begin
      src_addr = AW'(wp_ext - dist_ext);
    end else begin
      src_addr = AW'(wp_ext + DEPTH_W - dist_ext);
    end
  end

  // Every window write lands at the write position.
  assign mem_we    = cmd.clear_wr || take_lit || cmd.copy_emit;
  assign mem_wdata = cmd.clear_wr ? '0 : (take_lit ? in_packed_byte : rd_data_r);
  assign wp_nxt    = mem_we ? ((wp_r == TOP_POS) ? '0 : wp_r + AW'(1)) : wp_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      window_mem[wp_r] <= mem_wdata;
    end
    if (cmd.copy_rd) begin
      rd_data_r <= window_mem[src_addr];
    end
  end

  // Parser state update for an accepted byte.
  always_comb begin
    flag_nxt      = flag_r;
    left_nxt      = left_r;
    pair_high_nxt = pair_high_r;
    await_low_nxt = await_low_r;
    if (take_flag) begin
      flag_nxt = in_packed_byte;
      left_nxt = blzd_pkg::FLAG_COUNT;
    end else if (take_high) begin
      pair_high_nxt = in_packed_byte;
      await_low_nxt = 1'b1;
    end else if (take_low || take_lit) begin
      flag_nxt      = {flag_r[6:0], 1'b0};
      left_nxt      = left_r - blzd_pkg::LEFT_W'(1);
      await_low_nxt = 1'b0;
    end
    // A final byte always leaves the parser waiting for a flag byte.
    if (cmd.accept && in_final_byte) begin
      flag_nxt      = '0;
      left_nxt      = '0;
      pair_high_nxt = '0;
      await_low_nxt = 1'b0;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (take_low) begin
      cnt_nxt = blzd_pkg::LEN_W'(pair_high_r[7:4]) + blzd_pkg::LEN_BIAS;
    end else if (cmd.copy_emit) begin
      cnt_nxt = cnt_r - blzd_pkg::LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      flag_r      <= '0;
      left_r      <= '0;
      pair_high_r <= '0;
      await_low_r <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      flag_r      <= flag_nxt;
      left_r      <= left_nxt;
      pair_high_r <= pair_high_nxt;
      await_low_r <= await_low_nxt;
      cnt_r       <= cnt_nxt;
      if (take_lit || cmd.copy_emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_low) begin
      dist_r <= dist_new;
      fin_r  <= in_final_byte;
    end
    if (take_lit) begin
      out_byte_r    <= in_packed_byte;
      run_last_r    <= 1'b1;
      stream_done_r <= in_final_byte;
    end else if (cmd.copy_emit) begin
      out_byte_r    <= rd_data_r;
      run_last_r    <= sts.cnt_last;
      stream_done_r <= sts.cnt_last && fin_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_run_last    = run_last_r;
  assign out_stream_done = stream_done_r;

endmodule

FILE: rtl/core/backward_lz_decompressor_unit.sv
// ----------------------------------------------------------------------------
// backward_lz_decompressor_unit
// Backward LZ decompressor: compressed bytes in from the end of the image,
// decompressed bytes out in descending address order.
// ----------------------------------------------------------------------------
// After reset the unit zeroes its history window, one entry a cycle, and
// stalls the input until every entry is cleared. A flag byte, the high byte
// of a pair and a literal are each taken in the idle state; the low byte of a
// pair starts a copy of len bytes (3 to 18), each a read of the single-port
// window followed by a step that emits the byte and writes it back.
// A new request is taken only once the output register is free or being
// drained. The window and write position carry over from one stream to the
// next.
module backward_lz_decompressor_unit #(
  parameter int WINDOW_DEPTH = blzd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [blzd_pkg::BYTE_W-1:0] in_packed_byte,
  input  logic                        in_final_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [blzd_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_run_last,
  output logic                        out_stream_done
);

  blzd_pkg::blzd_cmd_t cmd;
  blzd_pkg::blzd_sts_t sts;

  blzd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  blzd_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_packed_byte  (in_packed_byte),
    .in_final_byte   (in_final_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_stream_done (out_stream_done)
  );

endmodule

FILE: rtl/core/blzd_checker.sv
// ----------------------------------------------------------------------------
// blzd_checker
// Port-level checks for the backward LZ decompressor, bound to the top level.
// ----------------------------------------------------------------------------
module blzd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [blzd_pkg::BYTE_W-1:0] out_byte,
  input logic                        out_run_last,
  input logic                        out_stream_done
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte)
      && $stable(out_run_last) && $stable(out_stream_done))
    else $error("stalled result changed");

  // The end of a stream is always the last byte of its request.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_done |-> out_run_last)
    else $error("stream_done without run_last");

  // No request is taken while a result is blocked in the output register.
  a_no_accept_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("request accepted while output blocked");

  // The window clearing pass blocks the input right after reset.
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> in_stall && !out_valid)
    else $error("input open or result shown during clearing pass");

endmodule

bind backward_lz_decompressor_unit blzd_checker u_blzd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte        (out_byte),
  .out_run_last    (out_run_last),
  .out_stream_done (out_stream_done)
);
